[sv/sha1_hash_engine_core_assert.svh]
// Assertion macros shared by the SHA-1 engine RTL.
// Depends on nothing; files include it by its bare name.
`ifndef SHA1_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA1_HASH_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SHA1_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1 engine: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SHA1_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1 engine: next-cycle check failed");

`endif

[sv/sha1_pkg.sv]
// Shared types and constants of the SHA-1 engine.
// Used by the schedule window, the round unit and the top level.
package sha1_pkg;

  localparam logic [1:0] MODE_ABSORB  = 2'd0;
  localparam logic [1:0] MODE_REPORT  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] PH_CH   = 2'd0;
  localparam logic [1:0] PH_PAR1 = 2'd1;
  localparam logic [1:0] PH_MAJ  = 2'd2;
  localparam logic [1:0] PH_PAR2 = 2'd3;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam logic [5:0]  LAST_POS    = 6'd63;
  localparam logic [5:0]  LEN_POS     = 6'd56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [2:0]  LAST_IDX    = 3'd4;

  localparam logic [31:0] SHA1_IV [0:4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

  // Control of the 16-word schedule window.
  typedef struct packed {
    logic       wr;
    logic [5:0] pos;
    logic [7:0] data;
    logic       shift;
  } sha1_wctl_t;

  // Control of the round unit and its chaining registers.
  typedef struct packed {
    logic       iv_load;
    logic       snap;
    logic       start;
    logic       use_copy;
    logic       step;
    logic [1:0] phase;
    logic       finish;
  } sha1_rctl_t;

endpackage

[sv/sha1_ram.sv]
// Generic single-port-write, registered-read RAM.
// Stand-alone; no package needed.
module sha1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/sha1_sched.sv]
// SHA-1 message schedule window: sixteen words, loaded a byte at a time
// and shifted once per round. Depends on sha1_pkg.
module sha1_sched (
  input  logic                clk,
  input  sha1_pkg::sha1_wctl_t ctl,
  output logic [31:0]         w0
);
  import sha1_pkg::*;

  logic [31:0] win [16];
  logic [31:0] mix;

  // Word t+16 from words t+13, t+8, t+2 and t, rotated left by one.
  assign mix = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w0  = win[0];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= {mix[30:0], mix[31]};
    end else if (ctl.wr) begin
      // Big-endian: byte lane 0 lands in bits 31:24.
      win[ctl.pos[5:2]][{~ctl.pos[1:0], 3'b000} +: 8] <= ctl.data;
    end
  end

endmodule

[sv/sha1_round.sv]
// SHA-1 round unit: working words a..e, the running chaining words and the
// copy used while a digest is reported. Depends on sha1_pkg.
module sha1_round (
  input  logic                clk,
  input  logic                rst,
  input  sha1_pkg::sha1_rctl_t ctl,
  input  logic [31:0]         w,
  input  logic [2:0]          sel,
  output logic [31:0]         word
);
  import sha1_pkg::*;

  logic [31:0] h  [5];
  logic [31:0] hv [5];
  logic [31:0] wk [5];
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  always_comb begin
    case (ctl.phase)
      PH_CH: begin
        f = (wk[1] & wk[2]) | (~wk[1] & wk[3]);
        k = SHA1_K0;
      end
      PH_PAR1: begin
        f = wk[1] ^ wk[2] ^ wk[3];
        k = SHA1_K1;
      end
      PH_MAJ: begin
        f = (wk[1] & wk[2]) | (wk[1] & wk[3]) | (wk[2] & wk[3]);
        k = SHA1_K2;
      end
      default: begin
        f = wk[1] ^ wk[2] ^ wk[3];
        k = SHA1_K3;
      end
    endcase
    tmp = {wk[0][26:0], wk[0][31:27]} + f + wk[4] + k + w;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 5; i++) begin
        wk[i] <= ctl.use_copy ? hv[i] : h[i];
      end
    end else if (ctl.step) begin
      wk[0] <= tmp;
      wk[1] <= wk[0];
      wk[2] <= {wk[1][1:0], wk[1][31:2]};
      wk[3] <= wk[2];
      wk[4] <= wk[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.iv_load) begin
      for (int i = 0; i < 5; i++) begin
        h[i] <= SHA1_IV[i];
      end
    end else if (ctl.finish && !ctl.use_copy) begin
      for (int i = 0; i < 5; i++) begin
        h[i] <= h[i] + wk[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.snap) begin
      for (int i = 0; i < 5; i++) begin
        hv[i] <= h[i];
      end
    end else if (ctl.finish && ctl.use_copy) begin
      for (int i = 0; i < 5; i++) begin
        hv[i] <= hv[i] + wk[i];
      end
    end
  end

  always_comb begin
    case (sel)
      3'd0:    word = hv[0];
      3'd1:    word = hv[1];
      3'd2:    word = hv[2];
      3'd3:    word = hv[3];
      default: word = hv[4];
    endcase
  end

endmodule

[sv/sha1_hash_engine_core.sv]
// SHA-1 engine, one message byte per absorb transfer, rounds run one per cycle.
// The 64th byte of a block starts the rounds on the shared round unit and then
// one chaining add. A report runs the load, the rounds and one add for each
// padded block, then reloads the window from the byte RAM, then makes five
// word transfers; input waits meanwhile.
// Synchronous rst restores the IV, clears count and length, not the byte RAM.
module sha1_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  output logic        word_valid,
  input  logic        word_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;
`include "sha1_hash_engine_core_assert.svh"

  // Sequencer states. The load state also rebuilds the schedule window from
  // the byte RAM after a report, since the rounds consume the window.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]  state;
  logic [6:0]  cnt;          // Load position (0..64) or round number (0..79).
  logic [5:0]  fill;         // Bytes held in the current block.
  logic [63:0] len;          // Message length in bits, wrapping.
  logic        job_report;   // The running compression belongs to a report.
  logic        blk;          // Second padded block of a report.
  logic        restore;      // Load pass only rebuilds the window.
  logic [2:0]  out_idx;

  logic        acc;
  logic [7:0]  ram_rdata;
  logic [5:0]  ld_pos;
  logic [7:0]  ld_byte;
  logic        two_blocks;
  logic        len_blk;
  logic [31:0] w0;

  sha1_wctl_t  wctl;
  sha1_rctl_t  rctl;

  assign item_ready  = (state == S_IDLE);
  assign acc         = item_valid && item_ready;
  assign word_valid  = (state == S_EMIT);
  assign word_index  = out_idx;
  assign last_word   = (out_idx == LAST_IDX);

  // The RAM read issued at position p is registered, so the byte
  // written during the load is for position cnt - 1.
  assign ld_pos     = cnt[5:0] - 6'd1;
  assign two_blocks = (fill >= LEN_POS);
  assign len_blk    = blk || !two_blocks;

  // Padded byte: message bytes, the 0x80 marker, zeros, and the big-endian bit
  // length in the last eight bytes of the final block; restore copies the RAM.
  always_comb begin
    if (restore || (!blk && ld_pos < fill)) begin
      ld_byte = ram_rdata;
    end else if (!blk && ld_pos == fill) begin
      ld_byte = PAD_BYTE;
    end else if (len_blk && ld_pos >= LEN_POS) begin
      ld_byte = len[{~ld_pos[2:0], 3'b000} +: 8];
    end else begin
      ld_byte = 8'h00;
    end
  end

  always_comb begin
    wctl          = '0;
    rctl          = '0;
    rctl.use_copy = job_report;
    rctl.phase    = (cnt < 7'd20) ? PH_CH :
                    (cnt < 7'd40) ? PH_PAR1 :
                    (cnt < 7'd60) ? PH_MAJ : PH_PAR2;
    unique case (state)
      S_IDLE: begin
        rctl.use_copy = 1'b0;
        if (acc) begin
          unique case (mode)
            MODE_ABSORB: begin
              wctl.wr   = 1'b1;
              wctl.pos  = fill;
              wctl.data = data_byte;
              rctl.start = (fill == LAST_POS);
            end
            MODE_REPORT:  rctl.snap    = 1'b1;
            MODE_RESTART: rctl.iv_load = 1'b1;
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        if (cnt != 7'd0) begin
          wctl.wr   = 1'b1;
          wctl.pos  = ld_pos;
          wctl.data = ld_byte;
        end
        rctl.start = (cnt == 7'd64) && !restore;
      end
      S_ROUND: begin
        wctl.shift = 1'b1;
        rctl.step  = 1'b1;
      end
      S_FINAL: rctl.finish = 1'b1;
      S_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= 7'd0;
      fill       <= 6'd0;
      len        <= 64'd0;
      job_report <= 1'b0;
      blk        <= 1'b0;
      restore    <= 1'b0;
      out_idx    <= 3'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (mode)
              MODE_ABSORB: begin
                len  <= len + 64'd8;
                fill <= fill + 6'd1;
                if (fill == LAST_POS) begin
                  job_report <= 1'b0;
                  cnt        <= 7'd0;
                  state      <= S_ROUND;
                end
              end
              MODE_REPORT: begin
                job_report <= 1'b1;
                blk        <= 1'b0;
                restore    <= 1'b0;
                cnt        <= 7'd0;
                state      <= S_LOAD;
              end
              MODE_RESTART: begin
                fill <= 6'd0;
                len  <= 64'd0;
              end
              default: ;
            endcase
          end
        end
        S_LOAD: begin
          if (cnt == 7'd64) begin
            cnt     <= 7'd0;
            out_idx <= 3'd0;
            state   <= restore ? S_EMIT : S_ROUND;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          if (cnt == 7'd79) begin
            cnt   <= 7'd0;
            state <= S_FINAL;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_FINAL: begin
          if (!job_report) begin
            state <= S_IDLE;
          end else if (!blk && two_blocks) begin
            blk   <= 1'b1;
            state <= S_LOAD;
          end else begin
            restore <= 1'b1;
            state   <= S_LOAD;
          end
        end
        S_EMIT: begin
          if (word_ready) begin
            if (out_idx == LAST_IDX) begin
              out_idx <= 3'd0;
              state   <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sha1_ram #(
    .WIDTH(8),
    .DEPTH(BLOCK_BYTES)
  ) u_bytes (
    .clk   (clk),
    .we    (acc && mode == MODE_ABSORB),
    .waddr (fill),
    .wdata (data_byte),
    .raddr (cnt[5:0]),
    .rdata (ram_rdata)
  );

  sha1_sched u_sched (
    .clk (clk),
    .ctl (wctl),
    .w0  (w0)
  );

  sha1_round u_round (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rctl),
    .w    (w0),
    .sel  (out_idx),
    .word (digest_word)
  );

  // The engine never takes input while digest words are pending.
  `SHA1_ASSERT_NOW(a_no_overlap, clk, rst, item_ready, !word_valid)
  // Rounds never run past the eightieth.
  `SHA1_ASSERT_NOW(a_round_range, clk, rst, state == S_ROUND, cnt < 7'd80)
  // A block compressed for absorbing returns straight to idle.
  `SHA1_ASSERT_NEXT(a_absorb_done, clk, rst, state == S_FINAL && !job_report,
                    item_ready)
  // The final digest word transfer frees the input side.
  `SHA1_ASSERT_NEXT(a_emit_done, clk, rst, word_valid && word_ready && last_word,
                    item_ready)

endmodule
